// ===== hw/rtl/ffba_pkg.sv =====
// shared types and constants for the first-fit block allocator
// no dependencies; imported by ffba_cell, ffba_ctrl, the top level and the checker

package ffba_pkg;

    localparam int ADDR_W = 20;
    localparam int SIZE_W = 21;
    localparam int BASE_W = 21;
    localparam int KEY_W  = 22;
    localparam int END_W  = 23;
    localparam int MODE_W = 2;
    localparam int TDATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    localparam logic [SIZE_W-1:0] POOL_LIMIT_RESET = 21'h100000;
    localparam logic [END_W-1:0]  ADDR_SPACE_END   = 23'h100000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } entry_t;

    typedef struct packed {
        logic              active;
        logic              op_free;
        logic              done;
        logic [KEY_W-1:0]  key;
        logic [BASE_W-1:0] hit_base;
        logic [SIZE_W-1:0] hit_size;
    } probe_t;

endpackage

// ===== hw/rtl/ffba_cell.sv =====
// one table cell: holds an entry and checks the passing probe against it
// depends on ffba_pkg

module ffba_cell #(
    parameter int CNT_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  ffba_pkg::entry_t     entry_in,
    output ffba_pkg::entry_t     entry_out,
    input  ffba_pkg::probe_t     probe_in,
    input  logic [CNT_W-1:0]     remaining_in,
    output ffba_pkg::probe_t     probe_out,
    output logic [CNT_W-1:0]     remaining_out
);
    import ffba_pkg::*;

    entry_t             entry_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic [CNT_W-1:0]   remaining_reg;
    logic [CNT_W-1:0]   remaining_next;
    logic               live;
    logic               match;
    logic               hit;

    assign live  = remaining_in != '0;
    assign match = probe_in.op_free ?
                   ({1'b0, entry_reg.base} == probe_in.key) :
                   (entry_reg.is_free && ({1'b0, entry_reg.size} >= probe_in.key));
    assign hit   = probe_in.active && !probe_in.done && live && match;

    always_comb
    begin
        probe_next     = probe_in;
        remaining_next = live ? remaining_in - CNT_W'(1) : remaining_in;
        if (hit)
        begin
            probe_next.done     = 1'b1;
            probe_next.hit_base = entry_reg.base;
            probe_next.hit_size = entry_reg.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            probe_reg     <= probe_next;
            remaining_reg <= remaining_next;
        end
    end

    // entry payload, undefined until shifted in
    always_ff @(posedge clk)
    begin
        if (shift_en)
            entry_reg <= entry_in;
        else if (hit)
            entry_reg.is_free <= probe_in.op_free;
    end

    assign entry_out     = entry_reg;
    assign probe_out     = probe_reg;
    assign remaining_out = remaining_reg;

endmodule

// ===== hw/rtl/ffba_ctrl.sv =====
// sequencer: takes beats, launches probes down the cell chain, carves new blocks
// depends on ffba_pkg

module ffba_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int CNT_W        = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ffba_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic [ffba_pkg::MODE_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ffba_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffba_pkg::SIZE_W-1:0]   cfg_data,
    output ffba_pkg::probe_t              launch,
    output logic [CNT_W-1:0]              launch_remaining,
    input  ffba_pkg::probe_t              result,
    output logic                          shift_en,
    output ffba_pkg::entry_t              shift_entry
);
    import ffba_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
    typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_CLEAR, OP_NOP} op_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [KEY_W-1:0]   aligned_reg;
    logic [END_W-1:0]   end_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SIZE_W-1:0]  bump_reg;
    logic [SIZE_W-1:0]  pool_limit_reg;
    probe_t             launch_reg;
    logic [CNT_W-1:0]   launch_rem_reg;
    logic               res_done_reg;
    logic [BASE_W-1:0]  res_base_reg;
    logic [SIZE_W-1:0]  res_size_reg;
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    status_t            m_status_reg;

    logic [SIZE_W-1:0]  in_request;
    logic [ADDR_W-1:0]  in_address;
    logic [KEY_W-1:0]   aligned_c;
    logic [END_W-1:0]   end_c;
    logic               accept;
    logic               out_free;
    logic               carve_ok;
    logic [BASE_W-1:0]  new_base;

    assign in_request = s_axis_tdata[SIZE_W-1:0];
    assign in_address = s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W];
    assign aligned_c  = ({1'b0, in_request} + KEY_W'(7)) & ~KEY_W'(7);
    assign end_c      = {2'b00, bump_reg} + END_W'(HEADER_BYTES) + {1'b0, aligned_c};

    assign s_axis_tready = state_reg == S_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign carve_ok = (count_reg != CNT_W'(MAX_BLOCKS)) &&
                      (end_reg <= {2'b00, pool_limit_reg}) &&
                      (end_reg <= ADDR_SPACE_END);
    assign new_base = BASE_W'({2'b00, bump_reg} + END_W'(HEADER_BYTES));

    assign shift_en = (state_reg == S_FINISH) && out_free && (op_reg == OP_ALLOC) &&
                      !res_done_reg && carve_ok;
    assign shift_entry.base    = new_base;
    assign shift_entry.size    = aligned_reg[SIZE_W-1:0];
    assign shift_entry.is_free = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_limit_reg <= POOL_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pool_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_NOP;
            aligned_reg    <= '0;
            end_reg        <= '0;
            count_reg      <= '0;
            bump_reg       <= '0;
            launch_reg     <= '0;
            launch_rem_reg <= '0;
            res_done_reg   <= 1'b0;
            res_base_reg   <= '0;
            res_size_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_status_reg   <= ST_OK;
        end
        else
        begin
            if (!accept)
                launch_reg.active <= 1'b0;
            if (m_valid_reg && m_axis_tready && state_reg != S_FINISH)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        aligned_reg    <= aligned_c;
                        end_reg        <= end_c;
                        launch_rem_reg <= count_reg;
                        res_done_reg   <= 1'b0;
                        unique case (s_axis_tuser)
                            MODE_ALLOC:
                            begin
                                op_reg     <= OP_ALLOC;
                                launch_reg <= '{active: 1'b1, op_free: 1'b0, done: 1'b0,
                                               key: aligned_c, hit_base: '0, hit_size: '0};
                                state_reg  <= S_SCAN;
                            end
                            MODE_FREE:
                            begin
                                if (in_address == '0)
                                begin
                                    op_reg    <= OP_NOP;
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    op_reg     <= OP_FREE;
                                    launch_reg <= '{active: 1'b1, op_free: 1'b1, done: 1'b0,
                                                   key: KEY_W'(in_address),
                                                   hit_base: '0, hit_size: '0};
                                    state_reg  <= S_SCAN;
                                end
                            end
                            MODE_RELEASE:
                            begin
                                op_reg    <= OP_CLEAR;
                                state_reg <= S_FINISH;
                            end
                            MODE_UNUSED:
                            begin
                                op_reg    <= OP_NOP;
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (result.active)
                    begin
                        res_done_reg <= result.done;
                        res_base_reg <= result.hit_base;
                        res_size_reg <= result.hit_size;
                        state_reg    <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        unique case (op_reg)
                            OP_ALLOC:
                            begin
                                if (res_done_reg)
                                begin
                                    m_data_reg   <= TDATA_W'({1'b1, res_size_reg,
                                                              res_base_reg[ADDR_W-1:0]});
                                    m_status_reg <= ST_OK;
                                end
                                else if (carve_ok)
                                begin
                                    m_data_reg   <= TDATA_W'({1'b0, aligned_reg[SIZE_W-1:0],
                                                              new_base[ADDR_W-1:0]});
                                    m_status_reg <= ST_OK;
                                    count_reg    <= count_reg + CNT_W'(1);
                                    bump_reg     <= end_reg[SIZE_W-1:0];
                                end
                                else
                                begin
                                    m_data_reg   <= '0;
                                    m_status_reg <= ST_NO_SPACE;
                                end
                            end
                            OP_FREE:
                            begin
                                m_data_reg <= '0;
                                if (res_done_reg)
                                    m_status_reg <= ST_OK;
                                else
                                    m_status_reg <= ST_NOT_FOUND;
                            end
                            OP_CLEAR:
                            begin
                                m_data_reg   <= '0;
                                m_status_reg <= ST_OK;
                                count_reg    <= '0;
                                bump_reg     <= '0;
                            end
                            OP_NOP:
                            begin
                                m_data_reg   <= '0;
                                m_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign launch           = launch_reg;
    assign launch_remaining = launch_rem_reg;
    assign m_axis_tvalid    = m_valid_reg;
    assign m_axis_tdata     = m_data_reg;
    assign m_axis_tuser     = m_status_reg;

endmodule

// ===== hw/rtl/first_fit_block_allocator_unit.sv =====
// top level of the first-fit block allocator: sequencer plus a chain of table cells
// depends on ffba_pkg, ffba_cell and ffba_ctrl
//
// usage
//   s_axis: one beat per command. tuser = mode (0 allocate, 1 free, 2 release all);
//   tdata = request_bytes then block_address. m_axis: exactly one beat per command,
//   tuser = status, tdata = granted_address, granted_size, was_reused.
//   cfg: single write-only register pool_limit, always ready; write only while idle.
// operation
//   allocate and free of a nonzero address send a probe through all MAX_BLOCKS
//   cells, one cell per cycle, before the result is formed; release all, free
//   of address 0 and the unused mode skip the probe and go to the final state.
//   one command is in flight at a time; s_axis_tready is high only when idle.
//   newest entry sits in the first cell; a carve shifts every entry one cell on.
// reset
//   table emptied (entry count and bump pointer zero), pool_limit = 1048576,
//   no clearing pass is needed; ready as soon as reset is released.
// stall
//   a finished result waits in the output register; the block stops in its final
//   state until m_axis_tready frees that register, holding all table state.

module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // request_bytes[20:0], block_address[40:21], zero fill
    input  logic [ffba_pkg::TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [ffba_pkg::MODE_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // granted_address[19:0], granted_size[40:20], was_reused[41], zero fill
    output logic [ffba_pkg::TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]                    m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffba_pkg::SIZE_W-1:0]   cfg_data
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    entry_t           entry_chain [MAX_BLOCKS+1];
    probe_t           probe_chain [MAX_BLOCKS+1];
    logic [CNT_W-1:0] rem_chain   [MAX_BLOCKS+1];
    logic             shift_en;

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .launch           (probe_chain[0]),
        .launch_remaining (rem_chain[0]),
        .result           (probe_chain[MAX_BLOCKS]),
        .shift_en         (shift_en),
        .shift_entry      (entry_chain[0])
    );

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        ffba_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .shift_en      (shift_en),
            .entry_in      (entry_chain[i]),
            .entry_out     (entry_chain[i+1]),
            .probe_in      (probe_chain[i]),
            .remaining_in  (rem_chain[i]),
            .probe_out     (probe_chain[i+1]),
            .remaining_out (rem_chain[i+1])
        );
    end

endmodule

// ===== hw/rtl/ffba_checker.sv =====
// port-level checks for first_fit_block_allocator_unit, attached by bind
// depends on ffba_pkg

module ffba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ffba_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                    m_axis_tuser
);
    import ffba_pkg::*;

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

    // one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

    // failed results carry no grant
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_SPACE || m_axis_tuser == ST_NOT_FOUND)
        |-> m_axis_tdata == '0)
    else $error("failed result with nonzero grant fields");

    // reuse only reported with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[ADDR_W+SIZE_W] |-> m_axis_tuser == ST_OK)
    else $error("reuse flagged on failed result");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
